[rtl/core/tangent_rational_approx_macros.svh]
// ----------------------------------------------------------------------------
// tangent_rational_approx_macros: assertion macros
// Implication checks, with and without a fixed delay, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef TANGENT_RATIONAL_APPROX_MACROS_SVH
`define TANGENT_RATIONAL_APPROX_MACROS_SVH

// ante implies cons in the same cycle
`define TRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// ante implies cons a fixed number of cycles later
`define TRA_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

[rtl/core/tra_pkg.sv]
// ----------------------------------------------------------------------------
// tra_pkg
// Formats, constants and rounding helpers for the tangent pipeline.
// ----------------------------------------------------------------------------
package tra_pkg;

    localparam int ANGLE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QF          = 30;
    localparam int NW          = 17;   // quadrant count width
    localparam int VW          = 34;   // num/den width
    localparam int QW          = 32;   // quotient bits
    localparam int DW          = 66;   // dividend / remainder width
    localparam int LATENCY     = 46;

    localparam logic signed [63:0] ONE_Q30       = 64'sd1 <<< QF;
    localparam logic signed [63:0] RECIP_HALF_PI = 64'sd683565276;
    localparam logic signed [63:0] C1_Q30        = 64'sd1686634496;
    localparam logic signed [63:0] C2_MAG_Q50    = 64'sd5015270586;
    localparam logic signed [63:0] P1_Q30        = -64'sd143219443;
    localparam logic signed [63:0] P2_Q30        = 64'sd3677445;
    localparam logic signed [63:0] P3_Q30        = -64'sd19179;
    localparam logic signed [63:0] Q1_Q30        = -64'sd501133384;
    localparam logic signed [63:0] Q2_Q30        = 64'sd27556330;
    localparam logic signed [63:0] Q3_Q30        = -64'sd334809;
    localparam logic signed [63:0] Q4_Q30        = 64'sd535;

    typedef logic signed [63:0] t_prod;
    typedef logic signed [VW-1:0] t_val;

    // Q30 product back to Q30, rounded half up
    function automatic t_val rnd30(input t_prod v);
        t_prod s;
        s = v + (64'sd1 <<< (QF - 1));
        return s[QF+VW-1:QF];
    endfunction

    // Q50 term to Q30, rounded half up
    function automatic t_prod rnd20(input t_prod v);
        t_prod s;
        s = v + (64'sd1 <<< 19);
        return s >>> 20;
    endfunction

endpackage

[rtl/core/tangent_rational_approx.sv]
// ----------------------------------------------------------------------------
// tangent_rational_approx
// Pipelined tangent of a signed Q16.16 angle, Q16.16 result with clamp flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive i_angle and pulse start. busy is always low, so a beat
//   is taken on every cycle that start is high, back to back with no gaps.
//   Output beat: o_done is high for one cycle with o_tangent and o_saturated.
//   Throughput: one beat per cycle.
//   Pipeline: rounding of x*2/pi (2 stages), reduction with the split pi/2
//   constant (2), squaring (2), Horner evaluation of numerator and
//   denominator in parallel (5), swap and sign/magnitude split (1), overflow
//   pre-check (1), one restoring quotient bit per stage (32), final clamp (1).
//   The quotient chain sets the depth.
//   Reset clears the valid bits only; beats in flight are dropped.
//   The receiver cannot stall: every result is shown exactly once.
// ----------------------------------------------------------------------------
`include "tangent_rational_approx_macros.svh"

module tangent_rational_approx
    import tra_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                          o_done,
    output logic signed [ANGLE_WIDTH-1:0] o_tangent,
    output logic                          o_saturated
);

    // valid bits for stages 1..12
    logic [12:1] r_v;

    // stage 1: angle times 2/pi
    logic signed [ANGLE_WIDTH-1:0] r1_x;
    t_prod                         r1_p;
    // stage 2: quadrant count
    logic signed [ANGLE_WIDTH-1:0] r2_x;
    logic signed [NW-1:0]          r2_n;
    // stage 3: n times both parts of pi/2
    logic signed [ANGLE_WIDTH-1:0] r3_x;
    t_prod                         r3_m1, r3_m2;
    logic                          r3_odd;
    // stage 4: reduced angle
    logic signed [31:0]            r4_f;
    logic                          r4_odd;
    // stage 5: f squared
    t_prod                         r5_sq;
    logic signed [31:0]            r5_f;
    logic                          r5_odd;
    // stage 6: g
    logic signed [31:0]            r6_g, r6_f;
    logic                          r6_odd;
    // stages 7..10: Horner products
    t_prod                         r7_a, r7_b, r8_a, r8_b, r9_a, r9_b, r10_a, r10_b;
    logic signed [31:0]            r7_g, r8_g, r9_g;
    logic signed [31:0]            r7_f, r8_f, r9_f, r10_f;
    logic [10:7]                   r_odd, r_gz;
    // stage 11: numerator, denominator
    t_val                          r11_num, r11_den;
    logic                          r11_odd;
    // stage 12: magnitudes
    logic [VW-1:0]                 r12_a, r12_b;
    logic                          r12_neg;

    // quotient chain, index 0 is the pre-check stage
    logic [DW-1:0]                 r_rem [0:QW];
    logic [VW-1:0]                 r_db  [0:QW];
    logic [QW-1:0]                 r_dq  [0:QW];
    logic                          r_dneg [0:QW];
    logic                          r_dovf [0:QW];
    logic [QW:0]                   r_dv;

    logic                          r_done, r_sat;
    logic signed [ANGLE_WIDTH-1:0] r_tan;

    // combinational helpers
    t_prod                         n_round_p, n_f64;
    t_val                          n_num, n_den, n_sn, n_sd;
    logic [DW-1:0]                 n_dvd;
    logic [ANGLE_WIDTH-1:0]        n_res;
    logic                          n_sat;

    assign busy = 1'b0;

    always_comb begin
        n_round_p = r1_p + (64'sd1 <<< (FRAC_BITS + QF - 1));
        n_f64     = (64'(r3_x) <<< (QF - FRAC_BITS)) - r3_m1 + rnd20(r3_m2);
        if (r_gz[10]) begin
            n_num = t_val'(r10_f);
            n_den = t_val'(ONE_Q30);
        end else begin
            n_num = rnd30(r10_a) + t_val'(r10_f);
            n_den = rnd30(r10_b) + t_val'(ONE_Q30);
        end
        if (r11_odd) begin
            n_sn = -r11_den;
            n_sd = r11_num;
        end else begin
            n_sn = r11_num;
            n_sd = r11_den;
        end
        n_dvd = (DW'(r12_a) << FRAC_BITS) + DW'(r12_b >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[11:1], start};
        end
        // stage 1
        r1_x <= i_angle;
        r1_p <= 64'(i_angle) * RECIP_HALF_PI;
        // stage 2
        r2_x <= r1_x;
        r2_n <= n_round_p[FRAC_BITS+QF+NW-1:FRAC_BITS+QF];
        // stage 3
        r3_x   <= r2_x;
        r3_m1  <= 64'(r2_n) * C1_Q30;
        r3_m2  <= 64'(r2_n) * C2_MAG_Q50;
        r3_odd <= r2_n[0];
        // stage 4
        r4_f   <= n_f64[31:0];
        r4_odd <= r3_odd;
        // stage 5
        r5_sq  <= 64'(r4_f) * 64'(r4_f);
        r5_f   <= r4_f;
        r5_odd <= r4_odd;
        // stage 6
        r6_g   <= 32'(rnd30(r5_sq));
        r6_f   <= r5_f;
        r6_odd <= r5_odd;
        // stage 7
        r7_a     <= P3_Q30 * 64'(r6_g);
        r7_b     <= Q4_Q30 * 64'(r6_g);
        r7_g     <= r6_g;
        r7_f     <= r6_f;
        r_odd[7] <= r6_odd;
        r_gz[7]  <= (r6_g == '0);
        // stage 8
        r8_a     <= (64'(rnd30(r7_a)) + P2_Q30) * 64'(r7_g);
        r8_b     <= (64'(rnd30(r7_b)) + Q3_Q30) * 64'(r7_g);
        r8_g     <= r7_g;
        r8_f     <= r7_f;
        r_odd[8] <= r_odd[7];
        r_gz[8]  <= r_gz[7];
        // stage 9
        r9_a     <= (64'(rnd30(r8_a)) + P1_Q30) * 64'(r8_g);
        r9_b     <= (64'(rnd30(r8_b)) + Q2_Q30) * 64'(r8_g);
        r9_g     <= r8_g;
        r9_f     <= r8_f;
        r_odd[9] <= r_odd[8];
        r_gz[9]  <= r_gz[8];
        // stage 10
        r10_a     <= 64'(rnd30(r9_a)) * 64'(r9_f);
        r10_b     <= (64'(rnd30(r9_b)) + Q1_Q30) * 64'(r9_g);
        r10_f     <= r9_f;
        r_odd[10] <= r_odd[9];
        r_gz[10]  <= r_gz[9];
        // stage 11
        r11_num <= n_num;
        r11_den <= n_den;
        r11_odd <= r_odd[10];
        // stage 12: sign/magnitude; zero divisor forces the negative clamp
        r12_a   <= n_sn[VW-1] ? VW'(-n_sn) : VW'(n_sn);
        r12_b   <= n_sd[VW-1] ? VW'(-n_sd) : VW'(n_sd);
        r12_neg <= (n_sn[VW-1] != n_sd[VW-1]) || (n_sd == '0);
    end

    // pre-check: quotient of 2^32 or more is a clamp outright
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_v[12];
        end
        r_rem[0]  <= n_dvd;
        r_db[0]   <= r12_b;
        r_dq[0]   <= '0;
        r_dneg[0] <= r12_neg;
        r_dovf[0] <= n_dvd >= (DW'(r12_b) << QW);
    end

    // one restoring quotient bit per stage, MSB first
    for (genvar gi = 1; gi <= QW; gi++) begin : g_div
        logic [DW-1:0] n_trial;
        logic          n_take;

        always_comb begin
            n_trial = DW'(r_db[gi-1]) << (QW - gi);
            n_take  = r_rem[gi-1] >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gi] <= 1'b0;
            end else begin
                r_dv[gi] <= r_dv[gi-1];
            end
            r_rem[gi]  <= n_take ? r_rem[gi-1] - n_trial : r_rem[gi-1];
            r_db[gi]   <= r_db[gi-1];
            r_dq[gi]   <= r_dq[gi-1] | (QW'(n_take) << (QW - gi));
            r_dneg[gi] <= r_dneg[gi-1];
            r_dovf[gi] <= r_dovf[gi-1];
        end
    end

    // final clamp and sign
    always_comb begin
        n_sat = 1'b0;
        if (r_dovf[QW]) begin
            n_sat = 1'b1;
        end else if (r_dneg[QW]) begin
            n_sat = r_dq[QW] > (QW'(1) << (ANGLE_WIDTH - 1));
        end else begin
            n_sat = r_dq[QW] > ((QW'(1) << (ANGLE_WIDTH - 1)) - QW'(1));
        end
        if (n_sat) begin
            n_res = r_dneg[QW] ? {1'b1, {(ANGLE_WIDTH-1){1'b0}}}
                               : {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
        end else if (r_dneg[QW]) begin
            n_res = -r_dq[QW];
        end else begin
            n_res = r_dq[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[QW];
        end
        r_tan <= n_res;
        r_sat <= n_sat;
    end

    assign o_done      = r_done;
    assign o_tangent   = r_tan;
    assign o_saturated = r_sat;

    `TRA_ASSERT_DLY(a_beat_emerges, i_clk, i_rst_n, start && $past(i_rst_n, LATENCY) && i_rst_n, LATENCY, o_done, "accepted beat did not emerge")
    `TRA_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_done, $past(start, LATENCY), "result without a matching beat")
    `TRA_ASSERT_IMP(a_clamp_value, i_clk, i_rst_n, o_done && o_saturated, o_tangent == {1'b0, {(ANGLE_WIDTH-1){1'b1}}} || o_tangent == {1'b1, {(ANGLE_WIDTH-1){1'b0}}}, "saturated result not at a range end")

endmodule

[verif/tangent_rational_approx_tb.sv]
// ----------------------------------------------------------------------------
// tangent_rational_approx_tb
// Drives directed angles then random bursts, predicts each tangent and clamp
// flag (table or independent fixed-point model) and checks results in order.
// ----------------------------------------------------------------------------
module tangent_rational_approx_tb;
    import tra_pkg::*;

    localparam int      N_RANDOM    = 830;
    localparam longint  CYCLE_LIMIT = 200000;

    // directed row: angle, and the expected result where it is obvious
    typedef struct packed {
        logic [31:0] angle;
        logic        known;
        logic [31:0] tan_exp;
        logic        sat_exp;
    } t_row;

    typedef struct packed {
        logic [31:0] tangent;
        logic        saturated;
    } t_tan;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic signed [ANGLE_WIDTH-1:0] i_angle;
    logic        o_done;
    logic signed [ANGLE_WIDTH-1:0] o_tangent;
    logic        o_saturated;

    t_tan   tan_queue[$];
    int     n_errors;
    longint cycle_count;
    logic   stim_done;

    t_row dir_table[] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},   // zero angle
        '{32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},   // tiny angle: tan = f
        '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},   // tiny negative
        '{32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},           // most positive
        '{32'h8000_0000, 1'b0, 32'h0, 1'b0},           // most negative
        '{32'h0000_C90F, 1'b0, 32'h0, 1'b0},           // near pi/4
        '{32'h0001_921F, 1'b0, 32'h0, 1'b0},           // near pi/2: odd n
        '{32'h0001_9220, 1'b0, 32'h0, 1'b0},
        '{32'hFFFE_6DE1, 1'b0, 32'h0, 1'b0},           // near -pi/2
        '{32'h0003_243F, 1'b0, 32'h0, 1'b0},           // near pi
        '{32'h0004_B65F, 1'b0, 32'h0, 1'b0},           // near 3pi/2
        '{32'h0000_C910, 1'b0, 32'h0, 1'b0},           // rounding boundary
        '{32'h0000_C90E, 1'b0, 32'h0, 1'b0},
        '{32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_0000, 1'b0, 32'h0, 1'b0},
        '{32'h5555_5555, 1'b0, 32'h0, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0},
        '{32'h0000_8000, 1'b0, 32'h0, 1'b0},
        '{32'h0000_4000, 1'b0, 32'h0, 1'b0}
    };

    tangent_rational_approx i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_angle    (i_angle),
        .o_done     (o_done),
        .o_tangent  (o_tangent),
        .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // round-half-up shift on wide signed values
    function automatic longint rshr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mq30(input longint a, input longint b);
        return rshr(a * b, QF);
    endfunction

    // tangent prediction: reduce by n*pi/2, rational form, quotient, clamp
    function automatic t_tan predict_tangent(input logic [31:0] angle);
        longint x, n, f, g, p, d, t;
        logic [63:0] a, b, q;
        logic neg;
        t_tan r;
        x = longint'($signed(angle));
        n = rshr(x * RECIP_HALF_PI, FRAC_BITS + QF);
        f = (x <<< (QF - FRAC_BITS)) - n * C1_Q30;
        f = f + rshr(n * C2_MAG_Q50, 20);
        g = mq30(f, f);
        if (g == 0) begin
            p = f;
            d = ONE_Q30;
        end else begin
            t = mq30(P3_Q30, g) + P2_Q30;
            t = mq30(t, g) + P1_Q30;
            t = mq30(t, g);
            p = mq30(t, f) + f;
            t = mq30(Q4_Q30, g) + Q3_Q30;
            t = mq30(t, g) + Q2_Q30;
            t = mq30(t, g) + Q1_Q30;
            d = mq30(t, g) + ONE_Q30;
        end
        if (n[0]) begin
            t = p;
            p = -d;
            d = t;
        end
        r.saturated = 1'b0;
        if (d == 0) begin
            r.tangent   = 32'h8000_0000;
            r.saturated = 1'b1;
        end else begin
            neg = (p < 0) != (d < 0);
            a = (p < 0) ? -p : p;
            b = (d < 0) ? -d : d;
            q = ((a << FRAC_BITS) + (b >> 1)) / b;
            if (neg && q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                r.saturated = 1'b1;
            end else if (!neg && q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
                r.saturated = 1'b1;
            end
            r.tangent = neg ? 32'(-q) : q[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_errors++;
    endtask

    // send one beat: raise start, hold until taken (busy low at the edge)
    task automatic send_angle(input logic [31:0] angle, input t_tan want);
        start   <= 1'b1;
        i_angle <= angle;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tan_queue.push_back(want);
    endtask

    // random angle: mostly small reduced ranges, some full-range noise
    function automatic logic [31:0] rand_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
        else if (sel < 6)
            return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
        else if (sel < 8) begin
            // hover around odd multiples of pi/4
            int k;
            k = $urandom_range(0, 40) - 20;
            return 32'(k * 32'sd102944 + 32'sd51472 + $signed($urandom_range(0, 8)) - 4);
        end
        return $urandom;
    endfunction

    // stimulus: directed table, then random bursts with gaps
    initial begin
        t_tan want;
        int   burst;
        n_errors    = 0;
        stim_done   = 1'b0;
        start       = 1'b0;
        i_angle     = '0;
        i_rst_n     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_table[k]) begin
            if (dir_table[k].known) begin
                want.tangent   = dir_table[k].tan_exp;
                want.saturated = dir_table[k].sat_exp;
            end else begin
                want = predict_tangent(dir_table[k].angle);
            end
            send_angle(dir_table[k].angle, want);
        end
        for (int k = 0; k < N_RANDOM; ) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && k < N_RANDOM; j++, k++) begin
                logic [31:0] ang;
                ang = rand_angle();
                send_angle(ang, predict_tangent(ang));
            end
            if ($urandom_range(0, 3) != 0) begin
                start   <= 1'b0;
                i_angle <= $urandom;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        stim_done <= 1'b1;
    end

    // result check: one beat per strobe against the oldest prediction
    always @(posedge i_clk) begin
        t_tan want;
        if (i_rst_n && o_done) begin
            if (tan_queue.size() == 0) begin
                report_mismatch("unexpected beat", o_tangent, 32'h0);
            end else begin
                want = tan_queue.pop_front();
                if (o_tangent !== want.tangent)
                    report_mismatch("tangent", o_tangent, want.tangent);
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", 32'(o_saturated),
                                    32'(want.saturated));
            end
        end
    end

    // end of run and watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (stim_done && tan_queue.size() == 0) begin
                repeat (LATENCY + 10) @(posedge i_clk);
                if (n_errors == 0)
                    $display("RESULT: OK");
                else
                    $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
